/* sv/pzbi_pkg.sv */
// Package for the polar zone blend indexer.
// Holds widths, latencies, register indexes, the CORDIC step-angle table and the result
// type. Depends on nothing.
package pzbi_pkg;

  localparam int CoordW      = 12;  // pixel row / column
  localparam int CfgW        = 13;  // widest configuration register
  localparam int CfgAddrW    = 2;
  localparam int RcW         = 5;   // radial zone count register
  localparam int AcW         = 7;   // angular zone count register
  localparam int XyW         = 14;  // doubled signed offset from the center
  localparam int SqHalfW     = 26;  // one squared offset
  localparam int SqW         = 28;  // sum of squares, padded to whole bit pairs
  localparam int RootW       = 30;  // floor(sqrt(s << 32))
  localparam int RemW        = 32;  // square-root remainder
  localparam int WgtW        = 4;   // radial scale max(R - 1, 1)
  localparam int NumW        = RootW + WgtW;
  localparam int QuotW       = 20;  // quotient bits kept, the rest folds into overflow
  localparam int DivRemW     = CfgW;
  localparam int FracW       = 16;
  localparam int AngW        = 24;
  localparam int CordicSteps = 20;
  localparam int CordicW     = 37;
  localparam int CordicScale = 20;  // inputs scaled by 2^20
  localparam int TqW         = FracW + AcW;
  localparam int RIdxW       = 4;
  localparam int TIdxW       = 6;
  localparam int ZoneW       = 10;
  localparam int ZoneProdW   = RIdxW + AcW;
  localparam int AngDly      = 32;  // aligns the angle path with the radial path
  localparam int PipeDepth   = 57;

  localparam logic [RcW-1:0] MaxRadial  = 5'd16;
  localparam logic [AcW-1:0] MaxAngular = 7'd64;

  localparam logic [CfgAddrW-1:0] RegImageRows  = 2'd0;
  localparam logic [CfgAddrW-1:0] RegImageCols  = 2'd1;
  localparam logic [CfgAddrW-1:0] RegRadialCnt  = 2'd2;
  localparam logic [CfgAddrW-1:0] RegAngularCnt = 2'd3;

  // step angles in units of 2^-24 turn
  localparam logic [AngW-1:0] CordicAngle [CordicSteps] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669,
    24'd83416,   24'd41718,   24'd20860,  24'd10430,  24'd5215,
    24'd2608,    24'd1304,    24'd652,    24'd326,    24'd163,
    24'd81,      24'd41,      24'd20,     24'd10,     24'd5
  };

  typedef struct packed {
    logic [TIdxW-1:0] t_lo;
    logic [TIdxW-1:0] t_hi;
    logic [FracW-1:0] t_wt;
  } ang_t;

  // first field in the highest bits
  typedef struct packed {
    logic [FracW-1:0] angular_weight;
    logic [FracW-1:0] radial_weight;
    logic [ZoneW-1:0] zone_outer_after;
    logic [ZoneW-1:0] zone_inner_after;
    logic [ZoneW-1:0] zone_outer_before;
    logic [ZoneW-1:0] zone_inner_before;
  } result_t;

endpackage

/* sv/pzbi_sqrt.sv */
// Pipelined floor square root of (s << 32), one result bit per stage.
// Depends on pzbi_pkg.
module pzbi_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [pzbi_pkg::SqW-1:0]    s_i,
  output logic [pzbi_pkg::RootW-1:0]  root_o
);
  import pzbi_pkg::*;

  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [SqW-1:0]   s_q    [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_step
    localparam int Bit = RootW - 1 - k;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [SqW-1:0]   s_in;
    logic [1:0]       pair;
    logic [RemW+1:0]  cand;
    logic [RemW+1:0]  trial;
    logic [RemW+1:0]  diff;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign s_in    = s_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign s_in    = s_q[k-1];
    end

    // low 32 bits of the radicand are zero
    if (Bit >= FracW) begin : g_pair
      assign pair = s_in[2*(Bit-FracW) +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    assign cand  = {rem_in, pair};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = cand - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k] <= s_in;
        if (cand >= trial) begin
          rem_q[k]  <= diff[RemW-1:0];
          root_q[k] <= {root_in[RootW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cand[RemW-1:0];
          root_q[k] <= {root_in[RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

/* sv/pzbi_div.sv */
// Pipelined restoring divider: low 20 quotient bits of num / m plus an overflow flag.
// Depends on pzbi_pkg.
module pzbi_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [pzbi_pkg::NumW-1:0]   num_i,
  input  logic [pzbi_pkg::CfgW-1:0]   m_i,
  output logic                        ovf_o,
  output logic [pzbi_pkg::QuotW-1:0]  quot_o
);
  import pzbi_pkg::*;

  localparam int HiW = NumW - QuotW;

  logic                 ovf_q  [QuotW+1];
  logic [DivRemW-1:0]   rem_q  [QuotW+1];
  logic [QuotW-1:0]     low_q  [QuotW+1];
  logic [QuotW-1:0]     quot_q [QuotW+1];

  // quotient of 2^20 or more: flag it and drop the high bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0]  <= num_i[NumW-1:QuotW] >= HiW'(m_i);
      rem_q[0]  <= num_i[QuotW +: DivRemW];
      low_q[0]  <= num_i[QuotW-1:0];
      quot_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic [DivRemW:0] cand;
    logic [DivRemW:0] diff;
    logic             ge;

    assign cand = {rem_q[k], low_q[k][QuotW-1-k]};
    assign diff = cand - {1'b0, m_i};
    assign ge   = cand >= {1'b0, m_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ovf_q[k+1]  <= ovf_q[k];
        low_q[k+1]  <= low_q[k];
        rem_q[k+1]  <= ge ? diff[DivRemW-1:0] : cand[DivRemW-1:0];
        quot_q[k+1] <= {quot_q[k][QuotW-2:0], ge};
      end
    end
  end

  assign ovf_o  = ovf_q[QuotW];
  assign quot_o = quot_q[QuotW];

endmodule

/* sv/pzbi_cordic.sv */
// Pipelined CORDIC in vectoring mode: angle of (x, y) as a Q0.16 turn.
// Depends on pzbi_pkg.
module pzbi_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [pzbi_pkg::XyW-1:0]   x_i,
  input  logic signed [pzbi_pkg::XyW-1:0]   y_i,
  output logic [pzbi_pkg::FracW-1:0]        turn_o
);
  import pzbi_pkg::*;

  localparam logic [FracW-1:0] TurnZero    = 16'h0000;
  localparam logic [FracW-1:0] TurnQuarter = 16'h4000;
  localparam logic [FracW-1:0] TurnHalf    = 16'h8000;
  localparam logic [FracW-1:0] TurnThree   = 16'hC000;
  localparam logic [AngW-1:0]  HalfAngle   = 24'h800000;

  logic signed [CordicW-1:0] x_q  [CordicSteps+1];
  logic signed [CordicW-1:0] y_q  [CordicSteps+1];
  logic [AngW-1:0]           z_q  [CordicSteps+1];
  logic                      sp_q [CordicSteps+1];
  logic [FracW-1:0]          sv_q [CordicSteps+1];

  logic signed [CordicW-1:0] xs;
  logic signed [CordicW-1:0] ys;
  logic [FracW-1:0]          sval;

  assign xs = {{(CordicW-XyW-CordicScale){x_i[XyW-1]}}, x_i, {CordicScale{1'b0}}};
  assign ys = {{(CordicW-XyW-CordicScale){y_i[XyW-1]}}, y_i, {CordicScale{1'b0}}};

  // axis cases bypass the iteration
  always_comb begin
    if (y_i == '0) begin
      sval = x_i[XyW-1] ? TurnHalf : TurnZero;
    end else begin
      sval = y_i[XyW-1] ? TurnThree : TurnQuarter;
    end
  end

  // fold the left half plane onto the right one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q[0] <= (y_i == '0) || (x_i == '0);
      sv_q[0] <= sval;
      if (x_i[XyW-1]) begin
        x_q[0] <= -xs;
        y_q[0] <= -ys;
        z_q[0] <= HalfAngle;
      end else begin
        x_q[0] <= xs;
        y_q[0] <= ys;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < CordicSteps; k++) begin : g_step
    logic signed [CordicW-1:0] xsh;
    logic signed [CordicW-1:0] ysh;
    logic                      ypos;

    assign xsh  = x_q[k] >>> k;
    assign ysh  = y_q[k] >>> k;
    assign ypos = !y_q[k][CordicW-1] && (y_q[k] != '0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sp_q[k+1] <= sp_q[k];
        sv_q[k+1] <= sv_q[k];
        if (ypos) begin
          x_q[k+1] <= x_q[k] + ysh;
          y_q[k+1] <= y_q[k] - xsh;
          z_q[k+1] <= z_q[k] + CordicAngle[k];
        end else begin
          x_q[k+1] <= x_q[k] - ysh;
          y_q[k+1] <= y_q[k] + xsh;
          z_q[k+1] <= z_q[k] - CordicAngle[k];
        end
      end
    end
  end

  assign turn_o = sp_q[CordicSteps] ? sv_q[CordicSteps]
                                    : z_q[CordicSteps][AngW-1 -: FracW];

endmodule

/* sv/polar_zone_blend_indexer.sv */
// Top level of the polar zone blend indexer: configuration registers, the radial and
// angular pipelines and the output queue. Depends on pzbi_pkg, pzbi_sqrt, pzbi_div and
// pzbi_cordic.
//
// Use: stream pixel coordinates in on s_axis (one beat per pixel, row in the low 12 bits,
// column above it). Each beat yields exactly one beat on m_axis with the four flat zone
// indices around the pixel and the radial and angular Q0.16 blend weights.
// Configuration (image rows, image columns, radial and angular zone counts, indexes 0..3)
// is written through cfg_we_i / cfg_addr_i / cfg_wdata_i while no beat is in flight.
// Throughput: one beat per cycle while the output queue has room or the sink is ready.
// Most stages of the 57-stage pipeline are one bit of the square root, one bit of the
// radius divider or one CORDIC step; the others hold the offsets, the squares, their sum,
// the clamp or a multiply. The 30 square-root and 21 divider stages are most of the depth.
// Reset clears the valid bits and the output queue and loads the registers with 512 rows,
// 512 columns, 5 radial and 12 angular zones.
// Stall: a two-beat output queue parts the pipeline from the sink; when it is full and the
// sink holds m_axis_tready low, the whole pipeline holds and s_axis_tready drops; nothing
// is lost or repeated.
module polar_zone_blend_indexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] pixel_row, [23:12] pixel_col
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [9:0] zone_inner_before, [19:10] zone_outer_before, [29:20] zone_inner_after,
  // [39:30] zone_outer_after, [55:40] radial_weight, [71:56] angular_weight
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [12:0] cfg_wdata_i
);
  import pzbi_pkg::*;

  // ---------------- configuration ----------------
  logic [CfgW-1:0] rows_q, cols_q;
  logic [RcW-1:0]  rzc_q;
  logic [AcW-1:0]  azc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 13'd512;
      cols_q <= 13'd512;
      rzc_q  <= 5'd5;
      azc_q  <= 7'd12;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegImageRows:  rows_q <= cfg_wdata_i;
        RegImageCols:  cols_q <= cfg_wdata_i;
        RegRadialCnt:  rzc_q  <= cfg_wdata_i[RcW-1:0];
        RegAngularCnt: azc_q  <= cfg_wdata_i[AcW-1:0];
        default: ;
      endcase
    end
  end

  // derived values, which the user must keep static while beats are in flight (not enforced)
  logic [RcW-1:0]   rc;
  logic [AcW-1:0]   ac;
  logic [CfgW-1:0]  m_side;
  logic [RcW-1:0]   rc_m1;
  logic [WgtW-1:0]  rlim;
  logic [WgtW-1:0]  w_scale;

  always_comb begin
    if (rzc_q == '0)            rc = 5'd1;
    else if (rzc_q > MaxRadial) rc = MaxRadial;
    else                        rc = rzc_q;
    if (azc_q == '0)             ac = 7'd1;
    else if (azc_q > MaxAngular) ac = MaxAngular;
    else                         ac = azc_q;
    m_side = (rows_q > cols_q) ? rows_q : cols_q;
    if (m_side == '0) m_side = 13'd1;
  end

  assign rc_m1   = rc - 5'd1;
  assign rlim    = rc_m1[WgtW-1:0];
  assign w_scale = (rc > 5'd1) ? rc_m1[WgtW-1:0] : 4'd1;

  // ---------------- handshake ----------------
  logic                 en;
  logic [1:0]           cnt_q;
  logic [PipeDepth-1:0] v_q;

  // advance while the output queue has room or is draining this cycle
  assign en            = (cnt_q != 2'd2) || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PipeDepth-2:0], s_axis_tvalid};
    end
  end

  // ---------------- stage 1: doubled offsets ----------------
  logic [CoordW-1:0]    in_row, in_col;
  logic [XyW:0]         x_full, y_full;
  logic signed [XyW-1:0] x1_q, y1_q;

  assign in_row = s_axis_tdata[CoordW-1:0];
  assign in_col = s_axis_tdata[2*CoordW-1:CoordW];
  assign x_full = {2'b00, in_col, 1'b0} - {2'b00, cols_q};
  assign y_full = {2'b00, in_row, 1'b0} - {2'b00, rows_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= x_full[XyW-1:0];
      y1_q <= y_full[XyW-1:0];
    end
  end

  // ---------------- radial path ----------------
  logic signed [2*XyW-1:0] px, py;
  logic [SqHalfW-1:0]      sqx_q, sqy_q;
  logic [SqW-1:0]          s_q;
  logic [RootW-1:0]        root;
  logic [NumW-1:0]         num_q;
  logic                    ovf;
  logic [QuotW-1:0]        quot;

  assign px = x1_q * x1_q;
  assign py = y1_q * y1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= px[SqHalfW-1:0];
      sqy_q <= py[SqHalfW-1:0];
      s_q   <= {2'b00, sqx_q} + {2'b00, sqy_q};
    end
  end

  pzbi_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (s_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= NumW'(root) * NumW'(w_scale);
    end
  end

  pzbi_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (num_q),
    .m_i    (m_side),
    .ovf_o  (ovf),
    .quot_o (quot)
  );

  // clamp past the outermost zone
  logic [RIdxW-1:0] r_int;
  logic             r_clamp;
  logic [RIdxW-1:0] r_lo_q, r_hi_q;
  logic [FracW-1:0] r_wt_q;

  assign r_int   = quot[QuotW-1:FracW];
  assign r_clamp = ovf || (r_int >= rlim);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (r_clamp) begin
        r_lo_q <= rlim;
        r_hi_q <= rlim;
        r_wt_q <= '0;
      end else begin
        r_lo_q <= r_int;
        r_hi_q <= r_int + RIdxW'(quot[FracW-1:0] != '0);
        r_wt_q <= quot[FracW-1:0];
      end
    end
  end

  // ---------------- angular path ----------------
  logic [FracW-1:0] turn;
  logic [TqW-1:0]   tq_q;
  logic [TIdxW-1:0] t_lo;
  logic [TIdxW:0]   t_up;
  logic             t_frac;
  ang_t             ang_d;
  ang_t             ang_q [AngDly+1];

  pzbi_cordic u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (x1_q),
    .y_i    (y1_q),
    .turn_o (turn)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      tq_q <= TqW'(turn) * TqW'(ac);
    end
  end

  assign t_lo   = tq_q[FracW +: TIdxW];
  assign t_frac = tq_q[FracW-1:0] != '0;
  assign t_up   = {1'b0, t_lo} + (TIdxW+1)'(t_frac);

  // wrap the upper angular neighbor
  always_comb begin
    ang_d.t_lo = t_lo;
    ang_d.t_wt = tq_q[FracW-1:0];
    if (t_up >= ac) begin
      ang_d.t_hi = TIdxW'(t_up - ac);
    end else begin
      ang_d.t_hi = t_up[TIdxW-1:0];
    end
  end

  // hold the angle results until the radial path catches up
  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0] <= ang_d;
      for (int i = 1; i <= AngDly; i++) begin
        ang_q[i] <= ang_q[i-1];
      end
    end
  end

  // ---------------- final stage: flat zone indices ----------------
  ang_t               ang_f;
  logic [ZoneProdW-1:0] base_lo, base_hi;
  logic [ZoneProdW-1:0] z_ib, z_ob, z_ia, z_oa;
  result_t            res_q;

  assign ang_f   = ang_q[AngDly];
  assign base_lo = ZoneProdW'(r_lo_q) * ZoneProdW'(ac);
  assign base_hi = ZoneProdW'(r_hi_q) * ZoneProdW'(ac);
  assign z_ib    = base_lo + ZoneProdW'(ang_f.t_lo);
  assign z_ob    = base_hi + ZoneProdW'(ang_f.t_lo);
  assign z_ia    = base_lo + ZoneProdW'(ang_f.t_hi);
  assign z_oa    = base_hi + ZoneProdW'(ang_f.t_hi);

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q.zone_inner_before <= z_ib[ZoneW-1:0];
      res_q.zone_outer_before <= z_ob[ZoneW-1:0];
      res_q.zone_inner_after  <= z_ia[ZoneW-1:0];
      res_q.zone_outer_after  <= z_oa[ZoneW-1:0];
      res_q.radial_weight     <= r_wt_q;
      res_q.angular_weight    <= ang_f.t_wt;
    end
  end

  // ---------------- output queue, two beats ----------------
  result_t fifo_q [2];
  logic    wr_ptr_q, rd_ptr_q;
  logic    push, pop;

  assign push = en && v_q[PipeDepth-1];
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      priority if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res_q;
    end
  end

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = fifo_q[rd_ptr_q];

endmodule
